>>> hdl/pmg_pkg.sv
// Shared widths, types and register codes of the point-mass gravity block.
// Depends on nothing; every other file of the block imports it.
package pmg_pkg;

	localparam int POS_W   = 32;              // Q16.16 positions and accelerations
	localparam int LANES   = 3;               // x, y, z
	localparam int MAG_W   = POS_W + 1;       // magnitude of a 33-bit difference
	localparam int SQ_W    = 2 * MAG_W;       // one squared component
	localparam int R2_W    = 66;              // |d|^2 + softening, Q32.32
	localparam int R2P_W   = R2_W + 2;        // padded to a whole number of digit pairs
	localparam int ROOT_W  = R2P_W / 2;       // floor square root, Q16.16
	localparam int SQRT_STEPS = ROOT_W;       // one root bit per stage
	localparam int REM_W   = ROOT_W + 2;      // square root partial remainder
	localparam int GM_W    = 2 * POS_W;       // G times mass, Q32.32
	localparam int DEN_W   = 99;              // r2 times root
	localparam int NUM_W   = 113;             // G*m*|d| scaled by 2^16
	localparam int Q_W     = 32;              // quotient bits below the overflow test
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 3;

	localparam logic [R2_W-1:0] SOFT_LSB = R2_W'(4295);
	localparam logic [Q_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [Q_W-1:0] NEG_LIMIT = 32'h8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X  = 3'd0,
		CFG_CENTER_Y  = 3'd1,
		CFG_CENTER_Z  = 3'd2,
		CFG_BODY_MASS = 3'd3,
		CFG_GRAV      = 3'd4
	} pmg_cfg_t;

	// Values that ride along the square root pipeline.
	typedef struct packed {
		logic [LANES-1:0]            neg;
		logic [LANES-1:0][MAG_W-1:0] mag;
		logic [GM_W-1:0]             gm;
		logic [R2_W-1:0]             r2;
	} pmg_carry_t;

endpackage

>>> hdl/pmg_pos_if.sv
// Input channel of the gravity block: one particle position per word.
// Depends on pmg_pkg.
interface pmg_pos_if import pmg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;

	modport source(output valid, pos_x, pos_y, pos_z, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, output ready);
endinterface

>>> hdl/pmg_acc_if.sv
// Output channel of the gravity block: one acceleration vector per word.
// Depends on pmg_pkg.
interface pmg_acc_if import pmg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [POS_W-1:0] accel_x;
	logic signed [POS_W-1:0] accel_y;
	logic signed [POS_W-1:0] accel_z;
	logic               saturated;

	modport source(output valid, accel_x, accel_y, accel_z, saturated, input ready);
	modport sink(input valid, accel_x, accel_y, accel_z, saturated, output ready);
endinterface

>>> hdl/point_mass_gravity_3d.sv
// Top level of the softened inverse-square gravity block, 3D, fixed point.
// Depends on pmg_pkg, pmg_pos_if and pmg_acc_if.

// The block takes one particle position word per clock, unless the output
// stalls, and returns the acceleration toward a single attracting body,
// a = G*m*d / (r2*sqrt(r2)), with d = center - pos and r2 = |d|^2 plus a
// softening of 4295 LSB in Q32.32. Positions and accelerations are signed
// Q16.16; each component saturates to 32 bits and the saturated flag marks a
// word in which any component clipped. The pipeline is 73 stages deep, and a
// new position is accepted in every cycle that the output is not stalled.
// The depth comes from the three input stages, the square root, which
// resolves one root bit per stage (34 stages), two multiply stages, the three
// parallel dividers, which resolve one quotient bit per stage (32 stages plus
// an overflow test), and the output register. When the output word is held,
// the whole pipeline holds.
// Configuration is written through cfg_we, cfg_index and cfg_data and must
// only change while no word is in flight; indexes beyond the list are ignored.
module point_mass_gravity_3d import pmg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	pmg_pos_if.sink              pos,
	pmg_acc_if.source            acc
);

	// Configuration registers.
	logic [POS_W-1:0] center_x_q, center_y_q, center_z_q;
	logic [POS_W-1:0] body_mass_q, grav_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q  <= '0;
			center_y_q  <= '0;
			center_z_q  <= '0;
			body_mass_q <= POS_W'(65536);
			grav_q      <= POS_W'(65536);
		end else if (cfg_we) begin
			unique case (pmg_cfg_t'(cfg_index))
				CFG_CENTER_X:  center_x_q  <= cfg_data;
				CFG_CENTER_Y:  center_y_q  <= cfg_data;
				CFG_CENTER_Z:  center_z_q  <= cfg_data;
				CFG_BODY_MASS: body_mass_q <= cfg_data;
				CFG_GRAV:      grav_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline advances together unless the output word is held.
	logic out_v_q;
	logic adv;
	assign adv = !out_v_q || acc.ready;
	assign pos.ready = adv;

	// Stage 1: differences, their signs and magnitudes, and G times mass.
	logic [LANES-1:0][POS_W-1:0] center, pos_arr;
	logic [LANES-1:0][MAG_W-1:0] diff, mag_c;
	logic [LANES-1:0]            neg_c;

	assign center  = {center_z_q, center_y_q, center_x_q};
	assign pos_arr = {pos.pos_z, pos.pos_y, pos.pos_x};

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			diff[l]  = {center[l][POS_W-1], center[l]} - {pos_arr[l][POS_W-1], pos_arr[l]};
			neg_c[l] = diff[l][MAG_W-1];
			mag_c[l] = neg_c[l] ? (~diff[l] + MAG_W'(1)) : diff[l];
		end
	end

	logic                        v_s1, v_s2, v_s3;
	logic [LANES-1:0][MAG_W-1:0] mag_s1, mag_s2;
	logic [LANES-1:0]            neg_s1, neg_s2;
	logic [GM_W-1:0]             gm_s1, gm_s2;
	logic [LANES-1:0][SQ_W-1:0]  sq_s2;
	pmg_carry_t                  carry_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pos.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1 <= mag_c;
			neg_s1 <= neg_c;
			gm_s1  <= {32'b0, grav_q} * {32'b0, body_mass_q};
			// Stage 2: squares.
			for (int l = 0; l < LANES; l++) begin
				sq_s2[l] <= {33'b0, mag_s1[l]} * {33'b0, mag_s1[l]};
			end
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			gm_s2  <= gm_s1;
			// Stage 3: softened squared distance.
			carry_s3.r2  <= sq_s2[0] + sq_s2[1] + sq_s2[2] + SOFT_LSB;
			carry_s3.mag <= mag_s2;
			carry_s3.neg <= neg_s2;
			carry_s3.gm  <= gm_s2;
		end
	end

	// Square root: digit-by-digit, one root bit per stage, two radicand bits in.
	logic                    sq_v    [SQRT_STEPS+1];
	pmg_carry_t              sq_c    [SQRT_STEPS+1];
	logic [REM_W-1:0]        sq_rem  [SQRT_STEPS+1];
	logic [ROOT_W-1:0]       sq_root [SQRT_STEPS+1];

	assign sq_v[0]    = v_s3;
	assign sq_c[0]    = carry_s3;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		logic [R2P_W-1:0] rad;
		logic [REM_W+1:0] tmp, trial;
		logic             ge;

		assign rad   = {2'b0, sq_c[k].r2};
		assign tmp   = {sq_rem[k], rad[R2P_W-1-2*k -: 2]};
		assign trial = {2'b0, sq_root[k], 2'b01};
		assign ge    = tmp >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k+1] <= 1'b0;
			end else if (adv) begin
				sq_v[k+1] <= sq_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_c[k+1]    <= sq_c[k];
				sq_rem[k+1]  <= ge ? REM_W'(tmp - trial) : REM_W'(tmp);
				sq_root[k+1] <= {sq_root[k][ROOT_W-2:0], ge};
			end
		end
	end

	// Two multiply stages: partial products, then their sums.
	pmg_carry_t                  fin_c;
	logic [ROOT_W-1:0]           root;
	logic                        v_m1, v_m2;
	logic [65:0]                 den_lo_m1;
	logic [67:0]                 den_hi_m1;
	logic [LANES-1:0][64:0]      num_lo_m1, num_hi_m1;
	logic [LANES-1:0]            neg_m1, neg_m2;
	logic [DEN_W-1:0]            den_m2;
	logic [LANES-1:0][NUM_W-1:0] num_m2;
	logic [99:0]                 den_sum;
	logic [LANES-1:0][96:0]      num_sum;

	assign fin_c = sq_c[SQRT_STEPS];
	assign root  = sq_root[SQRT_STEPS];
	assign den_sum = {den_hi_m1, 32'b0} + {34'b0, den_lo_m1};

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			num_sum[l] = {num_hi_m1[l], 32'b0} + {32'b0, num_lo_m1[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
		end else if (adv) begin
			v_m1 <= sq_v[SQRT_STEPS];
			v_m2 <= v_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_lo_m1 <= {34'b0, fin_c.r2[31:0]} * {32'b0, root};
			den_hi_m1 <= {34'b0, fin_c.r2[R2_W-1:32]} * {34'b0, root};
			for (int l = 0; l < LANES; l++) begin
				num_lo_m1[l] <= {33'b0, fin_c.gm[31:0]} * {32'b0, fin_c.mag[l]};
				num_hi_m1[l] <= {33'b0, fin_c.gm[GM_W-1:32]} * {32'b0, fin_c.mag[l]};
				num_m2[l]    <= {num_sum[l], 16'b0};
			end
			neg_m1 <= fin_c.neg;
			neg_m2 <= neg_m1;
			den_m2 <= den_sum[DEN_W-1:0];
		end
	end

	// Division: an overflow test on the top of the numerator, then one
	// quotient bit per stage for each lane, all sharing the denominator.
	logic                             dv_v   [Q_W+1];
	logic [DEN_W-1:0]                 dv_den [Q_W+1];
	logic [LANES-1:0]                 dv_neg [Q_W+1];
	logic [LANES-1:0]                 dv_ovf [Q_W+1];
	logic [LANES-1:0][DEN_W-1:0]      dv_r   [Q_W+1];
	logic [LANES-1:0][Q_W-1:0]        dv_low [Q_W+1];
	logic [LANES-1:0][Q_W-1:0]        dv_q   [Q_W+1];
	logic [LANES-1:0][DEN_W-1:0]      top_c;
	logic [LANES-1:0]                 ovf_c;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			top_c[l] = {18'b0, num_m2[l][NUM_W-1:Q_W]};
			ovf_c[l] = top_c[l] >= den_m2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (adv) begin
			dv_v[0] <= v_m2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_den[0] <= den_m2;
			dv_neg[0] <= neg_m2;
			dv_ovf[0] <= ovf_c;
			for (int l = 0; l < LANES; l++) begin
				dv_r[0][l]   <= ovf_c[l] ? '0 : top_c[l];
				dv_low[0][l] <= num_m2[l][Q_W-1:0];
				dv_q[0][l]   <= '0;
			end
		end
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_div
		logic [LANES-1:0][DEN_W:0] tmp;
		logic [LANES-1:0]          ge;

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				tmp[l] = {dv_r[k][l], dv_low[k][l][Q_W-1-k]};
				ge[l]  = tmp[l] >= {1'b0, dv_den[k]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k+1] <= 1'b0;
			end else if (adv) begin
				dv_v[k+1] <= dv_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_den[k+1] <= dv_den[k];
				dv_neg[k+1] <= dv_neg[k];
				dv_ovf[k+1] <= dv_ovf[k];
				dv_low[k+1] <= dv_low[k];
				for (int l = 0; l < LANES; l++) begin
					dv_r[k+1][l] <= ge[l] ? DEN_W'(tmp[l] - {1'b0, dv_den[k]})
						: DEN_W'(tmp[l]);
					dv_q[k+1][l] <= {dv_q[k][l][Q_W-2:0], ge[l]};
				end
			end
		end
	end

	// Output stage: clip, apply the sign, and hold the word until taken.
	logic [LANES-1:0][Q_W-1:0]   res_c;
	logic [LANES-1:0]            clip_c;
	logic [LANES-1:0][POS_W-1:0] out_q;
	logic                        out_sat_q;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			logic [Q_W-1:0] limit;
			logic [Q_W-1:0] m;
			limit     = dv_neg[Q_W][l] ? NEG_LIMIT : POS_LIMIT;
			clip_c[l] = dv_ovf[Q_W][l] || (dv_q[Q_W][l] > limit);
			m         = clip_c[l] ? limit : dv_q[Q_W][l];
			res_c[l]  = dv_neg[Q_W][l] ? (~m + Q_W'(1)) : m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= dv_v[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q     <= res_c;
			out_sat_q <= |clip_c;
		end
	end

	assign acc.valid     = out_v_q;
	assign acc.accel_x   = out_q[0];
	assign acc.accel_y   = out_q[1];
	assign acc.accel_z   = out_q[2];
	assign acc.saturated = out_sat_q;

endmodule

>>> hdl/pmg_checker.sv
// Port-level checks of the gravity block and the bind that attaches them.
// Depends on pmg_pkg and on point_mass_gravity_3d.
module pmg_checker import pmg_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             acc_valid,
	input logic             acc_ready,
	input logic [POS_W-1:0] accel_x,
	input logic [POS_W-1:0] accel_y,
	input logic [POS_W-1:0] accel_z,
	input logic             saturated,
	input logic             pos_ready
);

	// No result word is shown while reset is applied.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !acc_valid)
		else $error("result word valid during reset");

	// A held result word keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		acc_valid && !acc_ready |=> acc_valid && $stable(accel_x) && $stable(accel_y)
			&& $stable(accel_z) && $stable(saturated))
		else $error("held result word changed");

	// A clipped word has at least one component at a limit.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		acc_valid && saturated |-> accel_x == POS_LIMIT || accel_x == NEG_LIMIT
			|| accel_y == POS_LIMIT || accel_y == NEG_LIMIT
			|| accel_z == POS_LIMIT || accel_z == NEG_LIMIT)
		else $error("saturated flag without a clipped component");

	// The input side is open whenever the output side takes a word.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		acc_ready |-> pos_ready)
		else $error("input stalled while output is taken");

endmodule

bind point_mass_gravity_3d pmg_checker u_pmg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.acc_valid (acc.valid),
	.acc_ready (acc.ready),
	.accel_x   (acc.accel_x),
	.accel_y   (acc.accel_y),
	.accel_z   (acc.accel_z),
	.saturated (acc.saturated),
	.pos_ready (pos.ready)
);

>>> sim/testbench.sv
// Self-checking testbench of the point-mass gravity block.
// Depends on pmg_pkg, pmg_pos_if, pmg_acc_if and point_mass_gravity_3d.
module testbench;
	import pmg_pkg::*;

	typedef struct {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic               sat;
	} accel_t;

	// Register copies that the predictor works from.
	typedef struct {
		logic [31:0] cx, cy, cz, mass, grav;
	} body_t;

	// The scoreboard keeps one predicted acceleration per accepted position.
	class accel_board;
		accel_t pending[$];
		int errors;

		function automatic accel_t predict(body_t b, logic [31:0] px, logic [31:0] py,
				logic [31:0] pz);
			logic [32:0]  mag[3];
			logic         neg[3];
			logic [31:0]  cen[3];
			logic [31:0]  pin[3];
			logic [67:0]  r2;
			logic [33:0]  root;
			logic [33:0]  cand;
			logic [127:0] den;
			logic [63:0]  gm;
			logic [127:0] num;
			logic [127:0] q;
			logic [31:0]  lim;
			logic [31:0]  m;
			logic [31:0]  res[3];
			logic signed [33:0] d;
			accel_t a;
			cen = '{b.cx, b.cy, b.cz};
			pin = '{px, py, pz};
			r2 = 68'd4295;
			a.sat = 1'b0;
			for (int i = 0; i < 3; i++) begin
				d = $signed({cen[i][31], cen[i]}) - $signed({pin[i][31], pin[i]});
				neg[i] = d < 0;
				mag[i] = neg[i] ? 33'(-d) : 33'(d);
				r2 += 68'(mag[i]) * 68'(mag[i]);
			end
			// Bitwise floor square root, one bit at a time from the top.
			root = '0;
			for (int i = 33; i >= 0; i--) begin
				cand = root | (34'd1 << i);
				if (68'(cand) * 68'(cand) <= r2)
					root = cand;
			end
			den = 128'(r2) * 128'(root);
			gm = 64'(b.grav) * 64'(b.mass);
			for (int i = 0; i < 3; i++) begin
				num = (128'(gm) * 128'(mag[i])) << 16;
				q = num / den;
				lim = neg[i] ? NEG_LIMIT : POS_LIMIT;
				if (q > 128'(lim)) begin
					m = lim;
					a.sat = 1'b1;
				end else begin
					m = q[31:0];
				end
				res[i] = neg[i] ? -m : m;
			end
			a.ax = res[0];
			a.ay = res[1];
			a.az = res[2];
			return a;
		endfunction

		function void note_position(body_t b, logic [31:0] px, logic [31:0] py,
				logic [31:0] pz);
			pending.push_back(predict(b, px, py, pz));
		endfunction

		task automatic report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task automatic check_accel(accel_t got);
			accel_t exp_a;
			if (pending.size() == 0) begin
				report("acceleration word with no position waiting");
				return;
			end
			exp_a = pending.pop_front();
			if (got.ax !== exp_a.ax)
				report($sformatf("accel_x got %h want %h", got.ax, exp_a.ax));
			if (got.ay !== exp_a.ay)
				report($sformatf("accel_y got %h want %h", got.ay, exp_a.ay));
			if (got.az !== exp_a.az)
				report($sformatf("accel_z got %h want %h", got.az, exp_a.az));
			if (got.sat !== exp_a.sat)
				report($sformatf("saturated got %b want %b", got.sat, exp_a.sat));
		endtask
	endclass

	localparam int LATENCY = 73;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;
	body_t             body;
	accel_board        board;
	int                sent;
	int                rx_wait = 0;
	logic              stalls_on = 1'b1;

	pmg_pos_if pos();
	pmg_acc_if acc();

	point_mass_gravity_3d dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pos(pos.sink), .acc(acc.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		pos.valid = 1'b0;
		pos.pos_x = '0;
		pos.pos_y = '0;
		pos.pos_z = '0;
		acc.ready = 1'b0;
	end

	// Register write; the predictor's copy follows the same index decode so that
	// an index beyond the list is ignored on both sides.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_CENTER_X:  body.cx = val;
			CFG_CENTER_Y:  body.cy = val;
			CFG_CENTER_Z:  body.cz = val;
			CFG_BODY_MASS: body.mass = val;
			CFG_GRAV:      body.grav = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sends one position word, after a random gap, and waits for its handshake.
	// Valid stays high after the handshake so that a word with no gap can follow
	// at once; drain lowers it.
	task automatic send_position(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		int gap;
		gap = stalls_on ? $urandom_range(0, 5) : 0;
		if (gap != 0) begin
			pos.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pos.valid <= 1'b1;
		pos.pos_x <= px;
		pos.pos_y <= py;
		pos.pos_z <= pz;
		do
			@(posedge clk);
		while (!pos.ready);
		board.note_position(body, px, py, pz);
		sent++;
	endtask

	// Every result must drain before a register may change.
	task automatic drain;
		pos.valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
			default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
		endcase
	endfunction

	// After each word it takes, the receiver draws how many cycles it holds
	// ready low; phases with no stall run too.
	always @(posedge clk) begin
		if (!arst_n) begin
			acc.ready <= 1'b0;
			rx_wait = 0;
		end else if (acc.valid && acc.ready) begin
			board.check_accel('{acc.accel_x, acc.accel_y, acc.accel_z, acc.saturated});
			rx_wait = stalls_on ? $urandom_range(0, 5) : 0;
			acc.ready <= (rx_wait == 0);
		end else if (rx_wait != 0) begin
			rx_wait--;
			acc.ready <= (rx_wait == 0);
		end else begin
			acc.ready <= 1'b1;
		end
	end

	initial begin
		logic [31:0] corners[6];
		logic [31:0] mass_sets[4];
		logic [31:0] grav_sets[4];
		int mode;
		corners = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1, 32'h0001_0000};
		mass_sets = '{32'h0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0010_0000};
		grav_sets = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0, 32'h0000_4000};
		board = new();
		body = '{32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: particle on the body, extremes on each axis, tiny offsets.
		send_position(32'h0, 32'h0, 32'h0);
		foreach (corners[i]) begin
			send_position(corners[i], 32'h0, 32'h0);
			send_position(32'h0, corners[i], corners[(i + 1) % 6]);
		end
		send_position(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_position(32'h0, 32'h0, 32'h0000_0001);
		drain();
		// A write to an index beyond the list must change nothing.
		write_reg(3'd7, 32'hDEAD_BEEF);
		write_reg(3'd5, 32'h1234_5678);
		// Extreme center against extreme positions, with large G*m for saturation.
		write_reg(CFG_CENTER_X, 32'h7FFF_FFFF);
		write_reg(CFG_CENTER_Y, 32'h8000_0000);
		write_reg(CFG_CENTER_Z, 32'h0);
		write_reg(CFG_BODY_MASS, 32'hFFFF_FFFF);
		write_reg(CFG_GRAV, 32'hFFFF_FFFF);
		send_position(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
		send_position(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0100);
		send_position(32'h7FFF_FF00, 32'h8000_0010, 32'hFFFF_FFF0);
		drain();

		// Random phases, each with fresh registers; small offsets dominate so
		// that both saturated and ordinary results appear.
		for (int ph = 0; ph < 12; ph++) begin
			stalls_on = (ph % 4) != 3;
			write_reg(CFG_CENTER_X, (ph % 3 == 0) ? 32'h0 : $urandom());
			write_reg(CFG_CENTER_Y, $urandom());
			write_reg(CFG_CENTER_Z, (ph == 5) ? 32'h8000_0000 : $urandom());
			write_reg(CFG_BODY_MASS, (ph < 4) ? mass_sets[ph] : $urandom_range(0, 32'h00FF_FFFF));
			write_reg(CFG_GRAV, (ph < 4) ? grav_sets[ph] : $urandom());
			for (int k = 0; k < 150; k++) begin
				mode = $urandom_range(0, 2);
				if (mode == 0)
					send_position($urandom(), $urandom(), $urandom());
				else
					send_position(body.cx + rand_coord(mode), body.cy + rand_coord(mode),
						body.cz + rand_coord(mode));
			end
			drain();
		end

		stalls_on = 1'b1;
		drain();
		repeat (LATENCY + 20) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#3000000;
		$display("Verification failed");
		$finish;
	end
endmodule

>>> point_mass_gravity_3d.f
hdl/pmg_pkg.sv
hdl/pmg_pos_if.sv
hdl/pmg_acc_if.sv
hdl/point_mass_gravity_3d.sv
hdl/pmg_checker.sv
sim/testbench.sv
